// ===== hdl/sblp_pkg.sv =====
// Shared types and constants of the stack blur line pass.
// Holds the job descriptor and the fixed reciprocal tables; no dependencies.
package sblp_pkg;

  localparam int POS_W = 13;
  localparam int PTR_W = 7;
  localparam int RAD_W = 6;
  localparam int PIX_W = 32;
  localparam int ACC_W = 20;
  localparam int MUL_W = 10;
  localparam int SHR_W = 5;
  localparam int PROD_W = ACC_W + MUL_W;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] pos;
    logic [PTR_W-1:0] ptr;
    logic [RAD_W-1:0] radius;
    logic             last;
  } job_t;

  localparam logic [MUL_W-1:0] MUL_TAB [64] = '{
    10'd512, 10'd512, 10'd456, 10'd512, 10'd328, 10'd456, 10'd335, 10'd512,
    10'd405, 10'd328, 10'd271, 10'd456, 10'd388, 10'd335, 10'd292, 10'd512,
    10'd454, 10'd405, 10'd364, 10'd328, 10'd298, 10'd271, 10'd496, 10'd456,
    10'd420, 10'd388, 10'd360, 10'd335, 10'd312, 10'd292, 10'd273, 10'd512,
    10'd482, 10'd454, 10'd428, 10'd405, 10'd383, 10'd364, 10'd345, 10'd328,
    10'd312, 10'd298, 10'd284, 10'd271, 10'd259, 10'd496, 10'd475, 10'd456,
    10'd437, 10'd420, 10'd404, 10'd388, 10'd374, 10'd360, 10'd347, 10'd335,
    10'd323, 10'd312, 10'd302, 10'd292, 10'd282, 10'd273, 10'd265, 10'd512
  };

  localparam logic [SHR_W-1:0] SHR_TAB [64] = '{
    5'd9,  5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
    5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18,
    5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd19,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20,
    5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
    5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21
  };

endpackage

// ===== hdl/sblp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sblp_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sblp_front.sv =====
// Input side: holds the radius register, tracks line position and window slot,
// and turns each accepted pixel into a job descriptor. Uses sblp_pkg.
module sblp_front import sblp_pkg::*; #(
  parameter int MAX_RADIUS = 63,
  parameter int MAX_LINE   = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,
  input  logic             in_tlast,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int AW  = $clog2(WIN);
  localparam int PW  = $clog2(MAX_LINE);

  logic [RAD_W-1:0] radius_r, radius_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic             last;
  logic [RAD_W-1:0] rad_eff;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    rad_eff = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    last    = in_tlast || (pos_r >= PW'(MAX_LINE - 1));
    q_job.pixel  = in_tdata;
    q_job.pos    = POS_W'(pos_r);
    q_job.ptr    = PTR_W'(ptr_r);
    q_job.radius = rad_eff;
    q_job.last   = last;
    radius_nxt = cfg_valid ? cfg_data : radius_r;
    pos_nxt = pos_r;
    ptr_nxt = ptr_r;
    if (q_push) begin
      if (last) begin
        pos_nxt = '0;
        ptr_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
        ptr_nxt = (ptr_r == AW'(WIN - 1)) ? '0 : ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1);
      pos_r    <= '0;
      ptr_r    <= '0;
    end else begin
      radius_r <= radius_nxt;
      pos_r    <= pos_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

endmodule

// ===== hdl/sblp_fifo.sv =====
// Short job queue between the front and back parts of the blur pass.
// No dependencies.
module sblp_fifo #(
  parameter int W     = 59,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]    data_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW + 1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = data_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/sblp_back.sv =====
// Back part: stores each pixel in the window RAM, walks the taps of every
// due result, scales the sums and drives the output register. Uses sblp_pkg.
module sblp_back import sblp_pkg::*; #(
  parameter int MAX_RADIUS = 63
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int AW  = $clog2(WIN);
  localparam int JW  = RAD_W + 2;
  localparam int QW  = POS_W + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WRITE = 6'b000010,
    S_CALC  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_MUL   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic [POS_W-1:0]  x_r, x_nxt;
  logic signed [JW-1:0] j_r, j_nxt;
  logic              tap_vld_r, tap_vld_nxt;
  logic [RAD_W:0]    wgt_r, wgt_nxt;
  logic [ACC_W-1:0]  acc_r [4];
  logic [ACC_W-1:0]  acc_nxt [4];
  logic [PROD_W-1:0] prod_r [4];
  logic              out_vld_r, out_vld_nxt;
  logic [PIX_W-1:0]  out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic signed [JW-1:0] rad_s;
  logic signed [QW-1:0] q;
  logic [POS_W-1:0]  qc;
  logic [PTR_W:0]    bk, idx;
  logic [AW-1:0]     raddr;
  logic [PIX_W-1:0]  rdata;
  logic [RAD_W:0]    wgt_cur;
  logic [JW-1:0]     j_abs;
  logic [POS_W-1:0]  x0;
  logic [PROD_W-1:0] shifted [4];
  logic              out_free;

  sblp_ram #(.W(PIX_W), .DEPTH(WIN)) u_ram (
    .clk   (clk),
    .we    (state_r == S_WRITE),
    .waddr (job_r.ptr[AW-1:0]),
    .wdata (job_r.pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_vld_r || out_tready;

  always_comb begin
    rad_s = JW'(signed'({2'b00, job_r.radius}));
    q = QW'(signed'({2'b00, x_r})) + QW'(j_r);
    if (q < 0) begin
      qc = '0;
    end else if (q > QW'(signed'({2'b00, job_r.pos}))) begin
      qc = job_r.pos;
    end else begin
      qc = q[POS_W-1:0];
    end
    bk  = (PTR_W + 1)'(job_r.pos - qc);
    idx = ({1'b0, job_r.ptr} >= bk) ? ({1'b0, job_r.ptr} - bk)
                                    : ({1'b0, job_r.ptr} + (PTR_W + 1)'(WIN) - bk);
    raddr = idx[AW-1:0];
    j_abs = (j_r < 0) ? JW'(-j_r) : JW'(j_r);
    wgt_cur = (RAD_W + 1)'({1'b0, job_r.radius} + (RAD_W + 1)'(1) - j_abs[RAD_W:0]);
    x0 = (job_r.pos >= POS_W'(job_r.radius)) ? job_r.pos - POS_W'(job_r.radius) : '0;
    for (int c = 0; c < 4; c++) begin
      shifted[c] = prod_r[c] >> SHR_TAB[job_r.radius];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    x_nxt        = x_r;
    j_nxt        = j_r;
    tap_vld_nxt  = 1'b0;
    wgt_nxt      = wgt_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    for (int c = 0; c < 4; c++) begin
      acc_nxt[c] = acc_r[c];
      if (tap_vld_r) begin
        acc_nxt[c] = acc_r[c] + ACC_W'(wgt_r * rdata[8*c +: 8]);
      end
    end
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          job_nxt   = q_job;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        j_nxt = -rad_s;
        for (int c = 0; c < 4; c++) begin
          acc_nxt[c] = '0;
        end
        if (job_r.last) begin
          x_nxt     = x0;
          state_nxt = S_CALC;
        end else if (job_r.pos >= POS_W'(job_r.radius)) begin
          x_nxt     = x0;
          state_nxt = S_CALC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CALC: begin
        tap_vld_nxt = 1'b1;
        wgt_nxt     = wgt_cur;
        if (j_r == rad_s) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          for (int c = 0; c < 4; c++) begin
            out_data_nxt[8*c +: 8] = shifted[c][7:0];
          end
          out_last_nxt = job_r.last && (x_r == job_r.pos);
          if (!job_r.last || (x_r == job_r.pos)) begin
            state_nxt = S_IDLE;
          end else begin
            x_nxt = x_r + POS_W'(1);
            j_nxt = -rad_s;
            for (int c = 0; c < 4; c++) begin
              acc_nxt[c] = '0;
            end
            state_nxt = S_CALC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    x_r        <= x_nxt;
    j_r        <= j_nxt;
    wgt_r      <= wgt_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    for (int c = 0; c < 4; c++) begin
      acc_r[c] <= acc_nxt[c];
      if (state_r == S_MUL) begin
        prod_r[c] <= acc_r[c] * MUL_TAB[job_r.radius];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tap_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tap_vld_r <= tap_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ===== hdl/stack_blur_line_pass.sv =====
// Stack blur line pass, top level. A pixel that completes no result passes through
// the back end's idle and write states; each result runs the tap loop over the window RAM.
// Two jobs can queue ahead of the back end.
// A line end flushes up to r+1 results back to back through the same loop.
// Synchronous active-low reset clears control state and sets the radius to 1.
// No clearing pass: window entries are only read after being written.
module stack_blur_line_pass import sblp_pkg::*; #(
  parameter int MAX_RADIUS = 63,
  parameter int MAX_LINE   = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] cfg_data,   // blur_radius
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // pixel_in
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // pixel_out
  output logic             out_tlast
);

  job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_empty;

  sblp_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_LINE(MAX_LINE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  sblp_fifo #(.W($bits(job_t)), .DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_job),
    .empty (q_empty)
  );

  sblp_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/sblp_checker.sv =====
// Port-level checks for the stack blur line pass, bound to the top level.
// Depends on sblp_pkg and stack_blur_line_pass.
module sblp_checker import sblp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [PIX_W-1:0] out_tdata,
  input logic             out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled result request changed.");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result request shown right after reset.");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("Input not ready after reset with an empty queue.");

endmodule

bind stack_blur_line_pass sblp_checker u_sblp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== sim/tb_stack_blur_line_pass.sv =====
// Self-checking testbench for the stack blur line pass.
// Depends on sblp_pkg and stack_blur_line_pass; the blur is predicted in-house per request.
`timescale 1ns / 1ps
module tb_stack_blur_line_pass;
  import sblp_pkg::*;

  localparam int MAXR = 63;
  localparam int MAXL = 4096;
  localparam int DEPTH = 2 * MAXR + 1;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RAD_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [PIX_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;
  logic out_tlast;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stack_blur_line_pass u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),    // pixel_in
    .in_tlast(in_tlast),    // last_in_line
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata),  // pixel_out
    .out_tlast(out_tlast)   // line_done
  );

  typedef struct {
    logic [31:0] pix;
    logic        done;
  } blurred_t;

  blurred_t    blur_queue[$];
  logic [31:0] line_buf[DEPTH];
  int          cur_radius;
  int          line_pos;
  int          buf_ptr;
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          lines_sent = 0;
  longint      cycles = 0;
  bit          long_hold = 1'b0;
  bit          stall_on = 1'b1;

  function automatic logic [31:0] blur_one(int x, int p, int ptr, int r);
    logic [31:0] acc[4];
    logic [31:0] res;
    logic [63:0] v;
    logic [31:0] px;
    int q, back, idx, w;
    for (int c = 0; c < 4; c++) acc[c] = 0;
    for (int j = -r; j <= r; j++) begin
      q = x + j;
      if (q < 0) q = 0;
      if (q > p) q = p;
      back = p - q;
      idx = (ptr + DEPTH - (back % DEPTH)) % DEPTH;
      px = line_buf[idx];
      w = r + 1 - (j < 0 ? -j : j);
      for (int c = 0; c < 4; c++) acc[c] += w * ((px >> (8 * c)) & 32'hff);
    end
    res = 0;
    for (int c = 0; c < 4; c++) begin
      v = (64'(acc[c]) * MUL_TAB[r]) >> SHR_TAB[r];
      res |= (v[31:0] & 32'hff) << (8 * c);
    end
    return res;
  endfunction

  task automatic predict_blur(logic [31:0] pix, logic last);
    int r, p, ptr, x;
    blurred_t e;
    r = cur_radius;
    p = line_pos;
    ptr = buf_ptr;
    line_buf[ptr] = pix;
    if (p >= MAXL - 1) last = 1'b1;
    if (!last) begin
      if (p >= r) begin
        e.pix = blur_one(p - r, p, ptr, r);
        e.done = 1'b0;
        blur_queue.push_back(e);
      end
      buf_ptr = (ptr + 1 == DEPTH) ? 0 : ptr + 1;
      line_pos = (p + 1) & 16'h1fff;
    end else begin
      for (x = (p >= r ? p - r : 0); x <= p; x++) begin
        e.pix = blur_one(x, p, ptr, r);
        e.done = (x == p);
        blur_queue.push_back(e);
      end
      buf_ptr = 0;
      line_pos = 0;
      lines_sent++;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
  endtask

  always @(posedge clk) begin
    blurred_t e;
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        e = blur_queue.pop_front();
        if (out_tdata !== e.pix) report_mismatch("pixel_out", out_tdata, e.pix);
        if (out_tlast !== e.done) report_mismatch("line_done", out_tlast, e.done);
      end
      results_seen++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  always @(posedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
    end else if (!stall_on) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_pixel(logic [31:0] pix, logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_blur(pix, last);
    items_sent++;
    if ($urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_radius(int r);
    in_tvalid <= 1'b0;
    while (blur_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= r[RAD_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_radius = r;
  endtask

  task automatic send_line(int len, int mode);
    logic [31:0] pix;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: pix = $urandom();
        1: pix = (i % 2) ? 32'hffffffff : 32'h0;
        default: pix = {8'($urandom_range(0, 255)), 24'h0} | ($urandom() & 32'h00ffffff);
      endcase
      send_pixel(pix, i == len - 1);
    end
  endtask

  typedef struct {
    int          radius;
    logic [31:0] pix;
    logic        last;
    logic        has_want;
    logic [31:0] want;
  } step_row_t;

  step_row_t directed[] = '{
    '{1, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
    '{1, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
    '{0, 32'h12345678, 1'b1, 1'b1, 32'h12345678},
    '{0, 32'hffffffff, 1'b0, 1'b1, 32'hffffffff},
    '{0, 32'h00000000, 1'b1, 1'b1, 32'h00000000},
    '{63, 32'hffffffff, 1'b0, 1'b0, 0},
    '{63, 32'h80808080, 1'b0, 1'b0, 0},
    '{63, 32'h0000ffff, 1'b1, 1'b0, 0},
    '{2, 32'hff00ff00, 1'b0, 1'b0, 0},
    '{2, 32'h00ff00ff, 1'b0, 1'b0, 0},
    '{2, 32'hdeadbeef, 1'b0, 1'b0, 0},
    '{2, 32'h01020304, 1'b0, 1'b0, 0},
    '{2, 32'hcafef00d, 1'b0, 1'b0, 0},
    '{2, 32'hffffffff, 1'b1, 1'b0, 0}
  };

  initial begin
    int r, len;
    cur_radius = 1;
    line_pos = 0;
    buf_ptr = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      if (directed[k].radius != cur_radius) set_radius(directed[k].radius);
      if (directed[k].has_want) begin
        in_tvalid <= 1'b0;
        while (blur_queue.size() != 0) @(posedge clk);
        send_pixel(directed[k].pix, directed[k].last);
        if (blur_queue.size() == 0 || blur_queue[$].pix !== directed[k].want)
          report_mismatch("directed row", blur_queue.size() ? blur_queue[$].pix : 0,
                          directed[k].want);
      end else begin
        send_pixel(directed[k].pix, directed[k].last);
      end
    end

    // Long hold-off: the receiver stops while a line keeps streaming in.
    set_radius(3);
    fork
      send_line(40, 0);
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
    join

    // Radius changed within a line.
    send_pixel($urandom(), 1'b0);
    send_pixel($urandom(), 1'b0);
    send_pixel($urandom(), 1'b0);
    set_radius(1);
    send_line(4, 0);

    while (items_sent < 355) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: r = 0;
          1: r = 63;
          default: r = $urandom_range(1, 12);
        endcase
        set_radius(r);
      end
      stall_on = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      send_line(len, $urandom_range(0, 2));
    end
    in_tvalid <= 1'b0;

    while (blur_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d pixels in %0d lines at radii 0..63, %0d blurred pixels checked.",
             items_sent, lines_sent, results_seen);
    if (errors == 0 && blur_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
